@@ sv/tgn_pkg.sv @@
// Shared types, constants and color helpers for the TGA image normalizer.
package tgn_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int HDR_BYTES       = 18;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REJECTED  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	localparam logic [7:0] TYPE_PAL      = 8'd1;
	localparam logic [7:0] TYPE_TRUE     = 8'd2;
	localparam logic [7:0] TYPE_GREY     = 8'd3;
	localparam logic [7:0] TYPE_RLE_PAL  = 8'd9;
	localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
	localparam logic [7:0] TYPE_RLE_GREY = 8'd11;

	localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_ID,
		PH_MAP,
		PH_PIX,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        has_alpha;
		logic        top_origin;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [7:0]  run_length;
	} res_word_t;

	// What the parser hands to the second stage for one accepted byte.
	typedef struct packed {
		logic      main_v;
		logic      end_v;
		logic      use_pal;
		logic      miss;
		res_word_t main;
		logic [1:0] end_status;
	} s1_info_t;

	typedef struct packed {
		logic                  we;
		logic [PAL_AW-1:0]     waddr;
		logic [31:0]           wdata;
		logic [PAL_AW-1:0]     raddr;
	} pal_port_t;

	// Five-bit channel to eight bits, rounded down as x*255/31.
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [7:0] r;
		case (v)
			5'd0:  r = 8'd0;   5'd1:  r = 8'd8;   5'd2:  r = 8'd16;  5'd3:  r = 8'd24;
			5'd4:  r = 8'd32;  5'd5:  r = 8'd41;  5'd6:  r = 8'd49;  5'd7:  r = 8'd57;
			5'd8:  r = 8'd65;  5'd9:  r = 8'd74;  5'd10: r = 8'd82;  5'd11: r = 8'd90;
			5'd12: r = 8'd98;  5'd13: r = 8'd106; 5'd14: r = 8'd115; 5'd15: r = 8'd123;
			5'd16: r = 8'd131; 5'd17: r = 8'd139; 5'd18: r = 8'd148; 5'd19: r = 8'd156;
			5'd20: r = 8'd164; 5'd21: r = 8'd172; 5'd22: r = 8'd180; 5'd23: r = 8'd189;
			5'd24: r = 8'd197; 5'd25: r = 8'd205; 5'd26: r = 8'd213; 5'd27: r = 8'd222;
			5'd28: r = 8'd230; 5'd29: r = 8'd238; 5'd30: r = 8'd246; default: r = 8'd255;
		endcase
		return r;
	endfunction

	// Little-endian color word of 2, 3 or 4 bytes to packed BGRA.
	function automatic logic [31:0] decode_color(input logic [31:0] w, input logic [2:0] nb);
		logic [31:0] r;
		if (nb == 3'd2) begin
			r = {8'hFF, expand5(w[14:10]), expand5(w[9:5]), expand5(w[4:0])};
		end else if (nb == 3'd4) begin
			r = w;
		end else begin
			r = {8'hFF, w[23:0]};
		end
		return r;
	endfunction

endpackage

@@ sv/tga_image_normalizer.sv @@
// Top level of the streaming TGA image normalizer.
// Usage: the source offers one file byte per word on byte_word with byte_valid, and
// marks the last byte of each file with final_byte. The block answers on res_word:
// one header word, then pixel runs (color and repeat count), then one end status;
// a rejected file gets only the end status. A byte is taken when byte_valid is high
// and byte_stall low; a result word leaves when res_valid is high and res_stall low.
// Throughput: one byte per cycle while byte_stall is low. A byte's results pass
// through the second-stage registers, which line up with the palette RAM read, and
// then the result queue before they reach the output. The palette RAM has one write
// and one read port, enough for one map entry store or one palette lookup per byte.
// A byte can cause two words (a pixel run and the end status); a four-word queue
// holds them. byte_stall is high while the queue level plus the words in the second
// stage exceeds two, so a byte that causes two words can stall the input, and a
// receiver that holds res_stall high stops the input once the queue holds more than two.
// Reset clears the parser to the header state and empties the queue; the palette
// RAM is not cleared, since every entry a lookup can reach is written by the file's
// own color map first.
module tga_image_normalizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  tgn_pkg::in_word_t  byte_word,
	output logic               res_valid,
	input  logic               res_stall,
	output tgn_pkg::res_word_t res_word
);
	import tgn_pkg::*;

	s1_info_t   info;
	pal_port_t  pal;
	logic       acc;
	logic [31:0] pal_rdata;
	logic       main_v_s2, end_v_s2, use_pal_s2, miss_s2;
	res_word_t  main_s2;
	logic [1:0] end_st_s2;
	res_word_t  main_word, end_word;
	logic [2:0] level;
	logic [2:0] inflight;

	assign inflight   = {2'b00, main_v_s2} + {2'b00, end_v_s2};
	assign byte_stall = (level + inflight) > 3'd2;
	assign acc        = byte_valid && !byte_stall;

	tgn_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.word   (byte_word),
		.info   (info),
		.pal    (pal)
	);

	tgn_ram #(.WIDTH(32), .DEPTH(PALETTE_ENTRIES)) u_pal (
		.clk   (clk),
		.we    (pal.we),
		.waddr (pal.waddr),
		.wdata (pal.wdata),
		.raddr (pal.raddr),
		.rdata (pal_rdata)
	);

	// Second stage control, aligned with the palette read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_s2 <= 1'b0;
			end_v_s2  <= 1'b0;
		end else begin
			main_v_s2 <= info.main_v;
			end_v_s2  <= info.end_v;
		end
	end

	// Second stage payload.
	always_ff @(posedge clk) begin
		use_pal_s2 <= info.use_pal;
		miss_s2    <= info.miss;
		main_s2    <= info.main;
		end_st_s2  <= info.end_status;
	end

	// Palette colors are merged here; misses read as opaque black.
	always_comb begin
		main_word = main_s2;
		if (use_pal_s2) begin
			{main_word.alpha, main_word.red, main_word.green, main_word.blue} =
				miss_s2 ? OPAQUE_BLACK : pal_rdata;
		end
		end_word        = '0;
		end_word.kind   = KIND_END;
		end_word.status = end_st_s2;
	end

	tgn_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push0_v (main_v_s2),
		.push0   (main_word),
		.push1_v (end_v_s2),
		.push1   (end_word),
		.pop     (res_valid && !res_stall),
		.valid   (res_valid),
		.head    (res_word),
		.level   (level)
	);

endmodule

@@ sv/tgn_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module tgn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/tgn_parser.sv @@
// Byte parser: header, ID skip, color map load and pixel packet decode.
module tgn_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  tgn_pkg::in_word_t word,
	output tgn_pkg::s1_info_t info,
	output tgn_pkg::pal_port_t pal
);
	import tgn_pkg::*;

	phase_t      phase_q, phase_mid, phase_n;
	logic [4:0]  pos_q, pos_n;
	logic [7:0]  hdr_q [HDR_BYTES-1];
	logic        mp_q, mp_n;
	logic [7:0]  kind_q, kind_n;
	logic [15:0] first_q, first_n, cnt_q, cnt_n;
	logic [2:0]  meb_q, meb_n, pb_q, pb_n;
	logic [17:0] skip_q, skip_n;
	logic [23:0] asm_q, asm_n;
	logic [1:0]  idx_q, idx_n;
	logic [7:0]  pkt_q, pkt_n;
	logic        raw_q, raw_n;
	logic [31:0] pl_q, pl_n;
	logic [1:0]  outc_q, outc_n;
	logic [15:0] map_at_q, map_at_n;
	logic [15:0] w_q, w_n, h_q, h_n;

	logic [7:0]  b;
	logic        fin;
	logic        h_mp, h_dds, h_ok, h_reject;
	logic [7:0]  h_kind, h_bits, h_depth;
	logic [15:0] h_first, h_cnt, h_w, h_h;
	logic [2:0]  h_meb, h_pb;
	logic        sel_hdr, bm_mp;
	logic [15:0] bm_cnt, pix_w, pix_h;
	logic [2:0]  bm_meb;
	logic [31:0] area;
	logic [18:0] map_total;
	logic [31:0] unit_word;
	logic        map_more, pix_more, rle, pkt_hdr;
	logic [7:0]  pal_idx;
	logic [15:0] rel;
	logic        miss;
	logic [7:0]  run_raw, run_clip;
	logic [31:0] true_color, grey_color;

	assign b   = word.data_byte;
	assign fin = word.final_byte;

	// Decode of the header bytes, the current byte being the last one.
	always_comb begin
		h_mp    = hdr_q[1] == 8'd1;
		h_kind  = hdr_q[2];
		h_first = {hdr_q[4], hdr_q[3]};
		h_cnt   = {hdr_q[6], hdr_q[5]};
		h_w     = {hdr_q[13], hdr_q[12]};
		h_h     = {hdr_q[15], hdr_q[14]};
		h_bits  = hdr_q[7];
		h_depth = hdr_q[16];
		h_dds   = hdr_q[0] == 8'h44 && hdr_q[1] == 8'h44 && hdr_q[2] == 8'h53 && hdr_q[3] == 8'h20;
		h_ok    = ((h_kind == TYPE_PAL || h_kind == TYPE_GREY || h_kind == TYPE_RLE_PAL ||
			h_kind == TYPE_RLE_GREY) && h_depth == 8'd8) ||
			(h_kind == TYPE_RLE_TRUE && (h_depth == 8'd16 || h_depth == 8'd24 ||
			h_depth == 8'd32));
		h_reject = h_dds || !h_ok || h_w == 16'd0 || h_h == 16'd0 ||
			(h_mp && h_bits != 8'd16 && h_bits != 8'd24 && h_bits != 8'd32);
		h_meb = h_mp ? h_bits[5:3] : 3'd0;
		h_pb  = (h_kind == TYPE_RLE_TRUE) ? h_depth[5:3] : 3'd1;
	end

	// Shared datapath: entry assembly, map size, pixel count, palette range and runs.
	always_comb begin
		sel_hdr   = phase_q == PH_HEAD;
		bm_mp     = sel_hdr ? h_mp : mp_q;
		bm_cnt    = sel_hdr ? h_cnt : cnt_q;
		bm_meb    = sel_hdr ? h_meb : meb_q;
		pix_w     = sel_hdr ? h_w : w_q;
		pix_h     = sel_hdr ? h_h : h_q;
		area      = pix_w * pix_h;
		map_total = bm_cnt * bm_meb;
		unit_word = {8'h00, asm_q} | ({24'h0, b} << {idx_q, 3'b000});
		map_more  = ({1'b0, idx_q} + 3'd1) < meb_q;
		pix_more  = ({1'b0, idx_q} + 3'd1) < pb_q;
		rle       = kind_q >= TYPE_RLE_PAL;
		pkt_hdr   = rle && pkt_q == 8'd0;
		pal_idx   = unit_word[7:0];
		rel       = {8'h00, pal_idx} - first_q;
		miss      = !mp_q || cnt_q == 16'd0 || {8'h00, pal_idx} < first_q ||
			rel >= cnt_q || rel[15:8] != 8'd0;
		run_raw   = (rle && !raw_q) ? pkt_q : 8'd1;
		run_clip  = ({24'h0, run_raw} > pl_q) ? pl_q[7:0] : run_raw;
		true_color = decode_color(unit_word, pb_q);
		grey_color = {8'hFF, pal_idx, pal_idx, pal_idx};
	end

	// Next state of the parser.
	always_comb begin
		phase_mid = phase_q;
		pos_n = pos_q; mp_n = mp_q; kind_n = kind_q;
		first_n = first_q; cnt_n = cnt_q; meb_n = meb_q; pb_n = pb_q;
		skip_n = skip_q; asm_n = asm_q; idx_n = idx_q; pkt_n = pkt_q; raw_n = raw_q;
		pl_n = pl_q; outc_n = outc_q; map_at_n = map_at_q;
		w_n = w_q; h_n = h_q;
		unique case (phase_q)
			PH_HEAD: begin
				if (pos_q == 5'd17) begin
					mp_n = h_mp; kind_n = h_kind;
					first_n = h_first; cnt_n = h_cnt; w_n = h_w; h_n = h_h;
					if (h_reject) begin
						phase_mid = PH_DRAIN;
						outc_n    = ST_REJECTED;
					end else begin
						meb_n = h_meb; pb_n = h_pb;
						if (hdr_q[0] != 8'd0) begin
							phase_mid = PH_ID;
							skip_n    = {10'd0, hdr_q[0]};
						end else if (bm_mp && bm_cnt != 16'd0) begin
							phase_mid = PH_MAP;
							skip_n = map_total[17:0]; map_at_n = 16'd0;
							asm_n = 24'd0; idx_n = 2'd0;
						end else begin
							phase_mid = PH_PIX;
							pl_n = area; pkt_n = 8'd0; raw_n = 1'b0;
							asm_n = 24'd0; idx_n = 2'd0;
						end
					end
				end else begin
					pos_n = pos_q + 5'd1;
				end
			end
			PH_ID: begin
				skip_n = skip_q - 18'd1;
				if (skip_q == 18'd1) begin
					if (bm_mp && bm_cnt != 16'd0) begin
						phase_mid = PH_MAP;
						skip_n = map_total[17:0]; map_at_n = 16'd0;
						asm_n = 24'd0; idx_n = 2'd0;
					end else begin
						phase_mid = PH_PIX;
						pl_n = area; pkt_n = 8'd0; raw_n = 1'b0;
						asm_n = 24'd0; idx_n = 2'd0;
					end
				end
			end
			PH_MAP: begin
				if (map_more) begin
					asm_n = unit_word[23:0];
					idx_n = idx_q + 2'd1;
				end else begin
					map_at_n = map_at_q + 16'd1;
					asm_n = 24'd0; idx_n = 2'd0;
				end
				skip_n = skip_q - 18'd1;
				if (skip_q == 18'd1) begin
					phase_mid = PH_PIX;
					pl_n = area; pkt_n = 8'd0; raw_n = 1'b0;
					asm_n = 24'd0; idx_n = 2'd0;
				end
			end
			PH_PIX: begin
				if (pkt_hdr) begin
					pkt_n = {1'b0, b[6:0]} + 8'd1;
					raw_n = !b[7];
				end else if (pix_more) begin
					asm_n = unit_word[23:0];
					idx_n = idx_q + 2'd1;
				end else begin
					asm_n = 24'd0; idx_n = 2'd0;
					if (rle) begin
						pkt_n = raw_q ? pkt_q - 8'd1 : 8'd0;
					end
					pl_n = pl_q - {24'h0, run_clip};
					if (pl_n == 32'd0 && (!rle || pkt_n == 8'd0)) begin
						phase_mid = PH_DRAIN;
						outc_n    = ST_OK;
					end
				end
			end
			default: begin
			end
		endcase
		phase_n = phase_mid;
		if (fin) begin
			phase_n = PH_HEAD;
			pos_n   = 5'd0;
			outc_n  = ST_OK;
		end
	end

	// Items and palette port for the accepted byte.
	always_comb begin
		info       = '0;
		pal        = '0;
		pal.raddr  = rel[PAL_AW-1:0];
		pal.waddr  = map_at_q[PAL_AW-1:0];
		pal.wdata  = decode_color(unit_word, meb_q);
		unique case (phase_q)
			PH_HEAD: begin
				if (pos_q == 5'd17 && !h_reject) begin
					info.main_v                 = 1'b1;
					info.main.kind              = KIND_HEADER;
					info.main.image_width       = h_w;
					info.main.image_height      = h_h;
					info.main.has_alpha         = (h_mp && h_bits == 8'd32) || h_depth == 8'd32;
					info.main.top_origin        = b[5];
				end
			end
			PH_MAP: begin
				pal.we = acc && !map_more && map_at_q[15:PAL_AW] == '0;
			end
			PH_PIX: begin
				if (!pkt_hdr && !pix_more && run_clip != 8'd0) begin
					info.main_v          = 1'b1;
					info.main.kind       = KIND_PIXEL;
					info.main.run_length = run_clip;
					info.use_pal         = kind_q == TYPE_PAL || kind_q == TYPE_RLE_PAL;
					info.miss            = miss;
					if (kind_q == TYPE_RLE_TRUE) begin
						{info.main.alpha, info.main.red, info.main.green, info.main.blue} =
							true_color;
					end else begin
						{info.main.alpha, info.main.red, info.main.green, info.main.blue} =
							grey_color;
					end
				end
			end
			default: begin
			end
		endcase
		// The end status follows the phase reached after this byte; a drain that
		// starts on this byte is a rejection from the header or a finished image.
		if (fin) begin
			info.end_v = 1'b1;
			if (phase_mid == PH_HEAD) begin
				info.end_status = ST_REJECTED;
			end else if (phase_mid == PH_DRAIN) begin
				info.end_status = (phase_q == PH_DRAIN) ? outc_q
					: ((phase_q == PH_HEAD) ? ST_REJECTED : ST_OK);
			end else begin
				info.end_status = ST_TRUNCATED;
			end
		end
		info.main_v = info.main_v && acc;
		info.end_v  = info.end_v && acc;
	end

	// Header byte capture.
	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_HEAD && pos_q != 5'd17) begin
			hdr_q[pos_q] <= b;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD; pos_q <= '0; mp_q <= '0; kind_q <= '0;
			first_q <= '0; cnt_q <= '0; meb_q <= '0; pb_q <= '0; skip_q <= '0;
			asm_q <= '0; idx_q <= '0; pkt_q <= '0; raw_q <= '0; pl_q <= '0;
			outc_q <= '0; map_at_q <= '0; w_q <= '0; h_q <= '0;
		end else if (acc) begin
			phase_q <= phase_n; pos_q <= pos_n; mp_q <= mp_n;
			kind_q <= kind_n; first_q <= first_n; cnt_q <= cnt_n; meb_q <= meb_n;
			pb_q <= pb_n; skip_q <= skip_n; asm_q <= asm_n; idx_q <= idx_n;
			pkt_q <= pkt_n; raw_q <= raw_n; pl_q <= pl_n; outc_q <= outc_n;
			map_at_q <= map_at_n; w_q <= w_n; h_q <= h_n;
		end
	end

endmodule

@@ sv/tgn_outq.sv @@
// Four-word result queue that takes up to two words per cycle.
module tgn_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push0_v,
	input  tgn_pkg::res_word_t push0,
	input  logic               push1_v,
	input  tgn_pkg::res_word_t push1,
	input  logic               pop,
	output logic               valid,
	output tgn_pkg::res_word_t head,
	output logic [2:0]         level
);
	import tgn_pkg::*;

	res_word_t  buf_q [QUEUE_DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic [1:0] wp1;
	logic [2:0] n_push;

	assign valid  = cnt_q != 3'd0;
	assign head   = buf_q[rp_q];
	assign level  = cnt_q;
	assign wp1    = wp_q + {1'b0, push0_v};
	assign n_push = {2'b00, push0_v} + {2'b00, push1_v};

	// Storage; the second word lands behind the first when both arrive.
	always_ff @(posedge clk) begin
		if (push0_v) begin
			buf_q[wp_q] <= push0;
		end
		if (push1_v) begin
			buf_q[wp1] <= push1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[1:0];
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + n_push - {2'b00, pop};
		end
	end

endmodule

@@ sv/tgn_checker.sv @@
// Port-level checks for the TGA image normalizer and their bind.
module tgn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input tgn_pkg::res_word_t res_word
);
	import tgn_pkg::*;

	// A stalled result word stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("stalled result word changed");

	// A pixel run always repeats at least once.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.kind == KIND_PIXEL |-> res_word.run_length != 8'd0)
		else $error("pixel run of length zero");

	// An end status word carries no run length, no image width and no alpha.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.kind == KIND_END |->
		res_word.run_length == 8'd0 && res_word.image_width == 16'd0 &&
		res_word.alpha == 8'd0)
		else $error("end word carries payload");

endmodule

bind tga_image_normalizer tgn_checker u_tgn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);

@@ dv/tb_tga_image_normalizer.sv @@
// Self-checking testbench for the streaming TGA image normalizer.
`timescale 1ns / 100ps

module tb_tga_image_normalizer;
	import tgn_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	in_word_t  byte_word;
	logic      res_valid;
	logic      res_stall;
	res_word_t res_word;

	tga_image_normalizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_word(byte_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
	);

	// Decoder state mirrored for prediction.
	phase_t      dec_phase;
	int unsigned hdr_pos, id_left, map_kind_ok, img_kind, map_first, map_count;
	int unsigned map_bytes, pix_bytes, bytes_left, asm_word, asm_idx;
	int unsigned pkt_left, pkt_raw, pix_left, end_code, map_slot, width_px, height_px;
	logic [7:0]  hdr_bytes [HDR_BYTES];
	logic [31:0] palette [PALETTE_ENTRIES];

	res_word_t   expected_words [$];
	int          error_count;
	int          idle_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic [7:0]  file_bytes [$];

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void append_byte(int unsigned v);
		file_bytes = {file_bytes, 8'(v)};
	endfunction

	function automatic void expect_word(res_word_t w);
		expected_words = {expected_words, w};
	endfunction

	function automatic logic [7:0] chan5(int unsigned v);
		return 8'(((v & 32'h1F) * 255) / 31);
	endfunction

	function automatic logic [31:0] bgra_of(int unsigned w, int unsigned nb);
		if (nb == 2)
			return {8'hFF, chan5(w >> 10), chan5(w >> 5), chan5(w)};
		if (nb == 4)
			return w;
		return {8'hFF, w[23:0]};
	endfunction

	function automatic logic [31:0] palette_color(int unsigned idx);
		if (!map_kind_ok || map_count == 0 || idx < map_first)
			return OPAQUE_BLACK;
		if (idx - map_first >= map_count || idx - map_first >= PALETTE_ENTRIES)
			return OPAQUE_BLACK;
		return palette[idx - map_first];
	endfunction

	function automatic res_word_t blank_word(logic [1:0] k);
		res_word_t w;
		w = '0;
		w.kind = k;
		return w;
	endfunction

	function automatic void enter_pixels();
		dec_phase = PH_PIX;
		pix_left = width_px * height_px;
		pkt_left = 0;
		pkt_raw = 0;
		asm_word = 0;
		asm_idx = 0;
	endfunction

	function automatic void enter_map();
		if (map_kind_ok && map_count != 0) begin
			dec_phase = PH_MAP;
			bytes_left = map_count * map_bytes;
			map_slot = 0;
			asm_word = 0;
			asm_idx = 0;
		end else begin
			enter_pixels();
		end
	endfunction

	// Header decode: either rejects the file or queues the header word.
	function automatic void decode_header();
		int unsigned depth, bits;
		bit dds, ok;
		res_word_t w;
		depth = hdr_bytes[16];
		bits = hdr_bytes[7];
		dds = hdr_bytes[0] == 8'h44 && hdr_bytes[1] == 8'h44 && hdr_bytes[2] == 8'h53 &&
			hdr_bytes[3] == 8'h20;
		id_left = hdr_bytes[0];
		map_kind_ok = hdr_bytes[1] == 1;
		img_kind = hdr_bytes[2];
		map_first = {hdr_bytes[4], hdr_bytes[3]};
		map_count = {hdr_bytes[6], hdr_bytes[5]};
		width_px = {hdr_bytes[13], hdr_bytes[12]};
		height_px = {hdr_bytes[15], hdr_bytes[14]};
		ok = ((img_kind == TYPE_PAL || img_kind == TYPE_GREY || img_kind == TYPE_RLE_PAL ||
			img_kind == TYPE_RLE_GREY) && depth == 8) ||
			(img_kind == TYPE_RLE_TRUE && (depth == 16 || depth == 24 || depth == 32));
		if (dds || !ok || width_px == 0 || height_px == 0 ||
			(map_kind_ok && bits != 16 && bits != 24 && bits != 32)) begin
			dec_phase = PH_DRAIN;
			end_code = ST_REJECTED;
			return;
		end
		map_bytes = map_kind_ok ? bits / 8 : 0;
		pix_bytes = (img_kind == TYPE_RLE_TRUE) ? depth / 8 : 1;
		w = blank_word(KIND_HEADER);
		w.image_width = 16'(width_px);
		w.image_height = 16'(height_px);
		w.has_alpha = (map_kind_ok && bits == 32) || depth == 32;
		w.top_origin = hdr_bytes[17][5];
		expect_word(w);
		if (id_left != 0) begin
			dec_phase = PH_ID;
			bytes_left = id_left;
		end else begin
			enter_map();
		end
	endfunction

	// Pixel data byte: packet headers, color assembly and run emission.
	function automatic void decode_pixel(logic [7:0] b);
		bit rle;
		int unsigned w, run;
		logic [31:0] color;
		res_word_t r;
		rle = img_kind >= TYPE_RLE_PAL;
		run = 1;
		if (rle && pkt_left == 0) begin
			pkt_left = (b & 8'h7F) + 1;
			pkt_raw = !b[7];
			return;
		end
		if (asm_idx + 1 < pix_bytes) begin
			asm_word |= b << (8 * asm_idx);
			asm_idx++;
			return;
		end
		w = asm_word | (b << (8 * asm_idx));
		asm_word = 0;
		asm_idx = 0;
		if (img_kind == TYPE_PAL || img_kind == TYPE_RLE_PAL)
			color = palette_color(w & 8'hFF);
		else if (img_kind == TYPE_RLE_TRUE)
			color = bgra_of(w, pix_bytes);
		else
			color = {8'hFF, w[7:0], w[7:0], w[7:0]};
		if (rle) begin
			if (pkt_raw) begin
				pkt_left--;
			end else begin
				run = pkt_left;
				pkt_left = 0;
			end
		end
		if (run > pix_left)
			run = pix_left;
		if (run > 0) begin
			r = blank_word(KIND_PIXEL);
			{r.alpha, r.red, r.green, r.blue} = color;
			r.run_length = 8'(run);
			expect_word(r);
		end
		pix_left -= run;
		if (pix_left == 0 && (!rle || pkt_left == 0)) begin
			dec_phase = PH_DRAIN;
			end_code = ST_OK;
		end
	endfunction

	// Predict the result words for one accepted byte.
	function automatic void predict_byte(in_word_t iw);
		logic [7:0] b;
		res_word_t r;
		b = iw.data_byte;
		case (dec_phase)
			PH_HEAD: begin
				hdr_bytes[hdr_pos] = b;
				if (hdr_pos == HDR_BYTES - 1)
					decode_header();
				else
					hdr_pos++;
			end
			PH_ID: begin
				bytes_left--;
				if (bytes_left == 0)
					enter_map();
			end
			PH_MAP: begin
				if (asm_idx + 1 < map_bytes) begin
					asm_word |= b << (8 * asm_idx);
					asm_idx++;
				end else begin
					if (map_slot < PALETTE_ENTRIES)
						palette[map_slot] = bgra_of(asm_word | (b << (8 * asm_idx)), map_bytes);
					map_slot++;
					asm_word = 0;
					asm_idx = 0;
				end
				bytes_left--;
				if (bytes_left == 0)
					enter_pixels();
			end
			PH_PIX: decode_pixel(b);
			default: ;
		endcase
		if (iw.final_byte) begin
			r = blank_word(KIND_END);
			if (dec_phase == PH_HEAD)
				r.status = ST_REJECTED;
			else if (dec_phase == PH_DRAIN)
				r.status = 2'(end_code);
			else
				r.status = ST_TRUNCATED;
			expect_word(r);
			dec_phase = PH_HEAD;
			hdr_pos = 0;
			end_code = ST_OK;
		end
	endfunction

	// Send one byte, with random idle cycles before it. The stall is looked at
	// on the falling edge, where it already holds its value for the next rising edge.
	task automatic send_byte(logic [7:0] b, logic fin);
		in_word_t iw;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		iw.data_byte = b;
		iw.final_byte = fin;
		byte_valid <= 1'b1;
		byte_word <= iw;
		@(negedge clk);
		while (byte_stall)
			@(negedge clk);
		@(posedge clk);
		predict_byte(iw);
	endtask

	// Send the queued file bytes, marking the last one as final.
	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		file_bytes.delete();
	endtask

	task automatic push_header(int unsigned id_len, int unsigned cmap, int unsigned kind,
		int unsigned first, int unsigned count, int unsigned bits, int unsigned w,
		int unsigned h, int unsigned depth, int unsigned desc);
		append_byte(id_len);
		append_byte(cmap);
		append_byte(kind);
		append_byte(first[7:0]);
		append_byte(first[15:8]);
		append_byte(count[7:0]);
		append_byte(count[15:8]);
		append_byte(bits);
		repeat (4) append_byte($urandom_range(255));
		append_byte(w[7:0]);
		append_byte(w[15:8]);
		append_byte(h[7:0]);
		append_byte(h[15:8]);
		append_byte(depth);
		append_byte(desc);
	endtask

	// Build one well-formed random file, possibly cut short or padded.
	task automatic build_random_file();
		int unsigned kinds [6] = '{1, 3, 9, 10, 11, 1};
		int unsigned kind, cmap, bits, count, first, w, h, depth, id_len, npix, pbytes;
		int unsigned need, n, cut;
		kind = kinds[$urandom_range(5)];
		cmap = ($urandom_range(3) != 0) ? 1 : $urandom_range(255);
		bits = 8 * $urandom_range(2, 4);
		count = $urandom_range(9) == 0 ? $urandom_range(257, 300) : $urandom_range(0, 12);
		first = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(0, 8);
		w = $urandom_range(1, 5);
		h = $urandom_range(1, 4);
		if ($urandom_range(30) == 0) begin
			w = 16'hFFFF;
			h = 1;
		end
		depth = (kind == TYPE_RLE_TRUE) ? 8 * $urandom_range(2, 4) : 8;
		pbytes = depth / 8;
		id_len = $urandom_range(3) == 0 ? $urandom_range(1, 5) : 0;
		push_header(id_len, cmap, kind, first, count, bits, w, h, depth, $urandom_range(255));
		repeat (id_len) append_byte($urandom_range(255));
		if (cmap == 1)
			repeat (count * bits / 8) append_byte($urandom_range(255));
		npix = (w == 16'hFFFF) ? $urandom_range(20, 60) : w * h;
		need = npix;
		while (need > 0) begin
			if (kind >= TYPE_RLE_PAL) begin
				n = $urandom_range(1, 6);
				if ($urandom_range(15) == 0)
					n = 128;
				if ($urandom_range(1)) begin
					append_byte(8'h80 | (n - 1));
					repeat (pbytes) append_byte(
						(kind == TYPE_RLE_PAL) ? first + $urandom_range(count + 1) :
						$urandom_range(255));
				end else begin
					if (n > 8)
						n = 8;
					append_byte(n - 1);
					repeat (n * pbytes) append_byte(
						(kind == TYPE_RLE_PAL) ? first + $urandom_range(count + 1) :
						$urandom_range(255));
				end
				need = (n >= need) ? 0 : need - n;
			end else begin
				append_byte((kind == TYPE_PAL) ? first + $urandom_range(count + 1) :
					$urandom_range(255));
				need--;
			end
		end
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(1, 4)) append_byte($urandom_range(255));
		if ($urandom_range(9) == 0) begin
			cut = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
	endtask

	// Result checker with random receiver stalls.
	always @(posedge clk) begin
		res_word_t exp_w;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word %h", res_word);
					error_count++;
				end else begin
					exp_w = expected_words.pop_front();
					if (res_word.kind !== exp_w.kind) begin
						$error("kind: expected %0d, got %0d", exp_w.kind, res_word.kind);
						error_count++;
					end
					if (res_word.status !== exp_w.status) begin
						$error("status: expected %0d, got %0d", exp_w.status, res_word.status);
						error_count++;
					end
					if (res_word.image_width !== exp_w.image_width) begin
						$error("image_width: expected %0d, got %0d", exp_w.image_width,
							res_word.image_width);
						error_count++;
					end
					if (res_word.image_height !== exp_w.image_height) begin
						$error("image_height: expected %0d, got %0d", exp_w.image_height,
							res_word.image_height);
						error_count++;
					end
					if (res_word.has_alpha !== exp_w.has_alpha) begin
						$error("has_alpha: expected %0d, got %0d", exp_w.has_alpha,
							res_word.has_alpha);
						error_count++;
					end
					if (res_word.top_origin !== exp_w.top_origin) begin
						$error("top_origin: expected %0d, got %0d", exp_w.top_origin,
							res_word.top_origin);
						error_count++;
					end
					if (res_word.blue !== exp_w.blue) begin
						$error("blue: expected %0d, got %0d", exp_w.blue, res_word.blue);
						error_count++;
					end
					if (res_word.green !== exp_w.green) begin
						$error("green: expected %0d, got %0d", exp_w.green, res_word.green);
						error_count++;
					end
					if (res_word.red !== exp_w.red) begin
						$error("red: expected %0d, got %0d", exp_w.red, res_word.red);
						error_count++;
					end
					if (res_word.alpha !== exp_w.alpha) begin
						$error("alpha: expected %0d, got %0d", exp_w.alpha, res_word.alpha);
						error_count++;
					end
					if (res_word.run_length !== exp_w.run_length) begin
						$error("run_length: expected %0d, got %0d", exp_w.run_length,
							res_word.run_length);
						error_count++;
					end
				end
			end
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_tga_image_normalizer: done, errors");
			$finish;
		end
	end

	// Directed: short files, rejections and trailing bytes.
	task automatic test_rejections();
		for (int i = 0; i < 5; i++)
			append_byte(8'hFF);
		send_file();
		send_byte(8'h00, 1'b1);
		push_header(8'h44, 8'h44, 8'h53, 16'h0020, 0, 16, 1, 1, 8, 0);
		send_file();
		push_header(0, 0, TYPE_TRUE, 0, 0, 0, 1, 1, 24, 0);
		send_file();
		push_header(0, 0, TYPE_GREY, 0, 0, 0, 1, 1, 16, 0);
		send_file();
		push_header(0, 0, TYPE_GREY, 0, 0, 0, 0, 1, 8, 0);
		append_byte(8'h12);
		send_file();
		push_header(0, 1, TYPE_PAL, 0, 1, 15, 1, 1, 8, 0);
		send_file();
	endtask

	// Directed: field extremes, map of 16 bits, grey with trailing byte, truncation.
	task automatic test_extremes();
		push_header(0, 1, TYPE_PAL, 0, 2, 16, 2, 1, 8, 8'h20);
		append_byte(8'hFF);
		append_byte(8'h7F);
		append_byte(8'h00);
		append_byte(8'h00);
		append_byte(8'h00);
		append_byte(8'h07);
		send_file();
		push_header(2, 0, TYPE_GREY, 0, 0, 0, 1, 1, 8, 8'hFF);
		append_byte(8'h55);
		append_byte(8'hAA);
		append_byte(8'hFF);
		append_byte(8'h00);
		send_file();
		push_header(0, 0, TYPE_RLE_TRUE, 0, 0, 0, 16'hFFFF, 16'hFFFF, 32, 0);
		append_byte(8'hFF);
		repeat (4) append_byte(8'hFF);
		append_byte(8'h00);
		send_file();
		push_header(0, 0, TYPE_RLE_GREY, 0, 0, 0, 2, 1, 8, 0);
		append_byte(8'h02);
		append_byte(8'h10);
		append_byte(8'h20);
		append_byte(8'h30);
		send_file();
	endtask

	// Random files under one idling profile.
	task automatic test_random_files(int sender_pct, int receiver_pct, int byte_goal);
		int sent;
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
		sent = 0;
		while (sent < byte_goal) begin
			if ($urandom_range(19) == 0) begin
				repeat ($urandom_range(1, 30))
					append_byte($urandom_range(255));
			end else begin
				build_random_file();
			end
			sent += file_bytes.size();
			send_file();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_word = '0;
		res_stall = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		dec_phase = PH_HEAD;
		hdr_pos = 0;
		end_code = ST_OK;
		map_kind_ok = 0;
		map_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rejections();
		test_extremes();
		test_random_files(25, 48, 550);
		test_random_files(48, 25, 550);
		test_random_files(0, 0, 550);
		byte_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb_tga_image_normalizer: done, clean");
		else
			$display("tb_tga_image_normalizer: done, errors");
		$finish;
	end

endmodule

@@ tga_image_normalizer.f @@
sv/tgn_pkg.sv
sv/tgn_ram.sv
sv/tgn_parser.sv
sv/tgn_outq.sv
sv/tga_image_normalizer.sv
sv/tgn_checker.sv
dv/tb_tga_image_normalizer.sv
